// ===== hw/rtl/pareto_front_ranker_core_defines.svh =====
// Assertion macros shared by the ranker RTL.
`ifndef PARETO_FRONT_RANKER_CORE_DEFINES_SVH
`define PARETO_FRONT_RANKER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define PFR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PFR_ASSERT_NEVER(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);
`else
`define PFR_ASSERT(lbl, clk, rst_n, prop, msg)
`define PFR_ASSERT_NEVER(lbl, clk, rst_n, prop, msg)
`endif
`endif

// ===== hw/rtl/pfr_pkg.sv =====
package pfr_pkg;

  localparam int unsigned ObjW      = 32;
  localparam int unsigned ObjMax    = 3;
  localparam int unsigned IndexW    = 6;
  localparam int unsigned RankW     = 6;
  localparam int unsigned MaskW     = 3;

  typedef struct packed {
    logic signed [ObjW-1:0] objective_first;
    logic signed [ObjW-1:0] objective_second;
    logic signed [ObjW-1:0] objective_third;
    logic                   final_item;
  } pfr_in_t;

  typedef struct packed {
    logic [IndexW-1:0] member_index;
    logic [RankW-1:0]  front_rank;
    logic              run_end;
    logic              dropped;
  } pfr_out_t;

  // One stored individual, objective 0 in the lowest slot.
  typedef logic [ObjMax-1:0][ObjW-1:0] pfr_obj_t;

endpackage

// ===== hw/rtl/pareto_front_ranker_core.sv =====
// Pareto front ranker.
// Input channel (in_valid_i/in_ready_o, in_data_i): one individual per transfer,
// three signed Q16.16 objectives. Items are taken only while the block is
// loading; items beyond MAX_POP are discarded and flagged as dropped.
// A transfer with final_item set starts ranking of the stored set.
// Output channel (out_valid_o/out_ready_i, out_data_o): one result per stored
// individual in load order, with its front rank; run_end marks the last one.
// cfg_we_i writes the maximise mask; write it only while the block is idle.
// Loading accepts one item per cycle. Ranking first fills the dominance
// matrix one member row at a time (one comparator, one read of the
// objective memory per pair), then peels one front per pass over the
// stored members; the results are then presented one at a time.
// While a result is presented and out_ready_i is low, it is held and
// nothing advances.
// Reset clears the member count, drop flag, valid flags and state and sets the mask to 1;
// the memories are not cleared and need no sweep.
`include "pareto_front_ranker_core_defines.svh"
module pareto_front_ranker_core
  import pfr_pkg::*;
#(
  parameter int unsigned MAX_POP        = 64,
  parameter int unsigned NUM_OBJECTIVES = 3
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [MaskW-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  pfr_in_t          in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output pfr_out_t         out_data_o
);

  localparam int unsigned IW = $clog2(MAX_POP);
  localparam int unsigned CW = $clog2(MAX_POP + 1);
  localparam logic [MAX_POP-1:0] One = MAX_POP'(1);

  typedef enum logic [9:0] {
    S_LOAD     = 10'b0000000001,
    S_CMP_Q    = 10'b0000000010,
    S_CMP_LD   = 10'b0000000100,
    S_CMP_P    = 10'b0000001000,
    S_CMP_WR   = 10'b0000010000,
    S_PEEL_P   = 10'b0000100000,
    S_PEEL_END = 10'b0001000000,
    S_OUT_RD   = 10'b0010000000,
    S_OUT_WAIT = 10'b0100000000,
    S_OUT_HOLD = 10'b1000000000
  } state_e;

  state_e           state_q, state_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             ovf_q, ovf_d;
  logic [MaskW-1:0] mask_q;
  logic [IW-1:0]    q_q, q_d, p_q, p_d, o_q, o_d, rd_idx_q, rd_idx_d;
  logic [IW-1:0]    rank_q, rank_d;
  logic             rd_v_q, rd_v_d;
  pfr_obj_t         qobj_q, qobj_d;
  logic [MAX_POP-1:0] row_q, row_d, row_nx, rem_q, rem_d, rem_init;
  logic [MAX_POP-1:0] frt_q, frt_d, frt_nx;
  pfr_out_t         out_q, out_d;
  logic             out_v_q, out_v_d;

  logic               obj_we;
  pfr_obj_t           obj_wdata, obj_rdata;
  logic [IW-1:0]      obj_raddr;
  logic               dom_we;
  logic [MAX_POP-1:0] dom_rdata;
  logic               rank_we;
  logic [IW-1:0]      rank_rdata;
  logic               beats;
  logic               peel_hit;
  logic               last_p, last_q, last_o;

  assign obj_wdata = {in_data_i.objective_third, in_data_i.objective_second,
                      in_data_i.objective_first};

  pfr_ram #(.Width($bits(pfr_obj_t)), .Depth(MAX_POP)) u_obj_ram (
    .clk_i   (clk_i),
    .we_i    (obj_we),
    .waddr_i (cnt_q[IW-1:0]),
    .wdata_i (obj_wdata),
    .raddr_i (obj_raddr),
    .rdata_o (obj_rdata)
  );

  // Row q holds one bit for each member that dominates member q.
  pfr_ram #(.Width(MAX_POP), .Depth(MAX_POP)) u_dom_ram (
    .clk_i   (clk_i),
    .we_i    (dom_we),
    .waddr_i (q_q),
    .wdata_i (row_nx),
    .raddr_i (p_q),
    .rdata_o (dom_rdata)
  );

  pfr_ram #(.Width(IW), .Depth(MAX_POP)) u_rank_ram (
    .clk_i   (clk_i),
    .we_i    (rank_we),
    .waddr_i (rd_idx_q),
    .wdata_i (rank_q),
    .raddr_i (o_q),
    .rdata_o (rank_rdata)
  );

  pfr_dom #(.NumObj(NUM_OBJECTIVES)) u_dom (
    .a_i     (obj_rdata),
    .b_i     (qobj_q),
    .mask_i  (mask_q),
    .beats_o (beats)
  );

  assign last_p = (CW'(p_q) + CW'(1)) == cnt_q;
  assign last_q = (CW'(q_q) + CW'(1)) == cnt_q;
  assign last_o = (CW'(o_q) + CW'(1)) == cnt_q;

  assign row_nx = (rd_v_q && beats) ? (row_q | (One << rd_idx_q)) : row_q;

  // A remaining member with no remaining dominator belongs to this front.
  assign peel_hit = rd_v_q && rem_q[rd_idx_q] && ((dom_rdata & rem_q) == '0);
  assign frt_nx   = peel_hit ? (frt_q | (One << rd_idx_q)) : frt_q;

  always_comb begin
    for (int i = 0; i < MAX_POP; i++) begin
      rem_init[i] = CW'(i) < cnt_q;
    end
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    ovf_d     = ovf_q;
    q_d       = q_q;
    p_d       = p_q;
    o_d       = o_q;
    rank_d    = rank_q;
    rd_v_d    = 1'b0;
    rd_idx_d  = rd_idx_q;
    qobj_d    = qobj_q;
    row_d     = row_q;
    rem_d     = rem_q;
    frt_d     = frt_q;
    out_d     = out_q;
    out_v_d   = out_v_q;
    obj_we    = 1'b0;
    obj_raddr = p_q;
    dom_we    = 1'b0;
    rank_we   = 1'b0;
    in_ready_o = 1'b0;

    case (state_q)
      S_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (cnt_q < CW'(MAX_POP)) begin
            obj_we = 1'b1;
            cnt_d  = cnt_q + CW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (in_data_i.final_item) begin
            q_d     = '0;
            state_d = S_CMP_Q;
          end
        end
      end
      S_CMP_Q: begin
        obj_raddr = q_q;
        state_d   = S_CMP_LD;
      end
      S_CMP_LD: begin
        qobj_d  = obj_rdata;
        row_d   = '0;
        p_d     = '0;
        state_d = S_CMP_P;
      end
      S_CMP_P: begin
        row_d    = row_nx;
        rd_v_d   = 1'b1;
        rd_idx_d = p_q;
        if (last_p) begin
          state_d = S_CMP_WR;
        end else begin
          p_d = p_q + IW'(1);
        end
      end
      S_CMP_WR: begin
        dom_we = 1'b1;
        row_d  = row_nx;
        if (last_q) begin
          rem_d   = rem_init;
          rank_d  = '0;
          p_d     = '0;
          frt_d   = '0;
          state_d = S_PEEL_P;
        end else begin
          q_d     = q_q + IW'(1);
          state_d = S_CMP_Q;
        end
      end
      S_PEEL_P: begin
        rank_we  = peel_hit;
        frt_d    = frt_nx;
        rd_v_d   = 1'b1;
        rd_idx_d = p_q;
        if (last_p) begin
          state_d = S_PEEL_END;
        end else begin
          p_d = p_q + IW'(1);
        end
      end
      S_PEEL_END: begin
        rank_we = peel_hit;
        rem_d   = rem_q & ~frt_nx;
        frt_d   = '0;
        p_d     = '0;
        rank_d  = rank_q + IW'(1);
        if ((rem_q & ~frt_nx) == '0) begin
          o_d     = '0;
          state_d = S_OUT_RD;
        end else begin
          state_d = S_PEEL_P;
        end
      end
      S_OUT_RD: begin
        state_d = S_OUT_WAIT;
      end
      S_OUT_WAIT: begin
        out_v_d            = 1'b1;
        out_d.member_index = IndexW'(o_q);
        out_d.front_rank   = RankW'(rank_rdata);
        out_d.run_end      = last_o;
        out_d.dropped      = ovf_q;
        state_d            = S_OUT_HOLD;
      end
      S_OUT_HOLD: begin
        if (out_ready_i) begin
          out_v_d = 1'b0;
          if (out_q.run_end) begin
            cnt_d   = '0;
            ovf_d   = 1'b0;
            state_d = S_LOAD;
          end else begin
            o_d     = o_q + IW'(1);
            state_d = S_OUT_RD;
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      mask_q  <= MaskW'(1);
      rd_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
      rd_v_q  <= rd_v_d;
      out_v_q <= out_v_d;
      if (cfg_we_i) begin
        mask_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    q_q      <= q_d;
    p_q      <= p_d;
    o_q      <= o_d;
    rank_q   <= rank_d;
    rd_idx_q <= rd_idx_d;
    qobj_q   <= qobj_d;
    row_q    <= row_d;
    rem_q    <= rem_d;
    frt_q    <= frt_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  `PFR_ASSERT(a_cnt_range, clk_i, rst_ni, cnt_q <= CW'(MAX_POP), "member count exceeds capacity")
  `PFR_ASSERT_NEVER(a_no_load_while_out, clk_i, rst_ni, out_v_q && in_ready_o, "input taken during output")
  `PFR_ASSERT(a_peel_progress, clk_i, rst_ni, (state_q == S_PEEL_END) |-> (frt_nx != '0), "empty front")
  `PFR_ASSERT(a_set_restart, clk_i, rst_ni, (out_v_q && out_ready_i && out_q.run_end) |=> (cnt_q == '0 && !ovf_q && state_q == S_LOAD), "set not cleared after last result")

endmodule

// ===== hw/rtl/pfr_ram.sv =====
module pfr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/pfr_dom.sv =====
module pfr_dom
  import pfr_pkg::*;
#(
  parameter int unsigned NumObj = 3
) (
  input  pfr_obj_t         a_i,
  input  pfr_obj_t         b_i,
  input  logic [MaskW-1:0] mask_i,
  output logic             beats_o
);

  // a dominates b: never worse, strictly better at least once.
  always_comb begin
    logic worse;
    logic better;
    worse  = 1'b0;
    better = 1'b0;
    for (int k = 0; k < NumObj; k++) begin
      if (mask_i[k]) begin
        worse  = worse  | ($signed(a_i[k]) < $signed(b_i[k]));
        better = better | ($signed(a_i[k]) > $signed(b_i[k]));
      end else begin
        worse  = worse  | ($signed(a_i[k]) > $signed(b_i[k]));
        better = better | ($signed(a_i[k]) < $signed(b_i[k]));
      end
    end
    beats_o = better & ~worse;
  end

endmodule
